// File: design/sm3_hash_engine_top_macros.svh
// ----------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Property wrappers clocked on i_clk with the reset i_rst_n masked out.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_TOP_MACROS_SVH
`define SM3_HASH_ENGINE_TOP_MACROS_SVH

// Flag any cycle where cond holds.
`define SM3_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Require cons in the cycle after ante.
`define SM3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Transfer types, SM3 constants and the round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_digest_word;
    } t_out_item;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [31:0] T_LOW     = 32'h79CC4519;
    localparam logic [31:0] T_HIGH    = 32'h7A879D8A;
    localparam logic [31:0] PAD_MSB   = 32'h80000000;
    localparam logic [3:0]  CNT_LEN_HI = 4'd14;
    localparam logic [3:0]  CNT_LEN_LO = 4'd15;
    localparam logic [5:0]  ROUND_LAST = 6'd63;
    localparam logic [2:0]  DIGEST_LAST = 3'd7;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // Keep the leading n bytes, place 0x80 right after them (n below 4).
    function automatic logic [31:0] pad_partial(input logic [31:0] w, input logic [1:0] n);
        logic [31:0] keep;
        logic [4:0]  sh;
        sh   = {n, 3'b000};
        keep = ~(32'hFFFFFFFF >> sh);
        if (n == 2'd0) begin
            keep = 32'h0;
        end
        return (w & keep) | (PAD_MSB >> sh);
    endfunction

endpackage

`default_nettype wire

// File: design/sm3_hash_engine_top.sv
// ----------------------------------------------------------------------------
// SM3 hash engine top level
// Word-serial SM3 with a 16-word shifting message window and one shared round
// unit stepped once per cycle by a small sequencer.
// Input: words are taken while idle; the 16th word of a block starts the rounds,
//   during which no word is taken.
// Last word: padding words are pushed, then one or two blocks of rounds, then 8
//   digest transfers, one per cycle while the sink is ready.
// Reset: synchronous; loads the IV, clears length, counters and flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sm3_hash_engine_top_macros.svh"

module sm3_hash_engine_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  sm3_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output sm3_pkg::t_out_item  o_out_data
);
    import sm3_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_PAD   = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]  r_state,    n_state;
    logic [3:0]  r_cnt,      n_cnt;
    logic [5:0]  r_round,    n_round;
    logic [2:0]  r_idx,      n_idx;
    logic [63:0] r_bitlen,   n_bitlen;
    logic        r_pad_act,  n_pad_act;
    logic        r_pend80,   n_pend80;
    logic        r_len_hi,   n_len_hi;
    logic        r_len_done, n_len_done;
    logic [31:0] r_cv  [8];
    logic [31:0] n_cv  [8];
    logic [31:0] r_wr  [8];
    logic [31:0] n_wr  [8];
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];

    logic        in_xfer;
    logic        out_xfer;
    logic [2:0]  n_eff;
    logic        push_en;
    logic [31:0] push_word;

    logic        early;
    logic [31:0] tj;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] a12;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] tt1;
    logic [31:0] tt2;
    logic [31:0] w_new;
    logic [31:0] rnd [8];

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data.digest_word      = r_cv[r_idx];
    assign o_out_data.digest_index     = r_idx;
    assign o_out_data.last_digest_word = (r_idx == DIGEST_LAST);

    assign n_eff = (i_in_data.valid_bytes > FULL_BYTES) ? FULL_BYTES : i_in_data.valid_bytes;

    // Shared round unit and message expansion
    always_comb begin
        early = (r_round[5:4] == 2'b00);
        tj    = rotl32(early ? T_LOW : T_HIGH, r_round[4:0]);
        if (early) begin
            ff = r_wr[0] ^ r_wr[1] ^ r_wr[2];
            gg = r_wr[4] ^ r_wr[5] ^ r_wr[6];
        end else begin
            ff = (r_wr[0] & r_wr[1]) | (r_wr[0] & r_wr[2]) | (r_wr[1] & r_wr[2]);
            gg = (r_wr[4] & r_wr[5]) | (~r_wr[4] & r_wr[6]);
        end
        a12 = rotl32(r_wr[0], 5'd12);
        ss1 = rotl32(a12 + r_wr[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        tt1 = ff + r_wr[3] + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gg + r_wr[7] + ss1 + r_win[0];
        rnd[0] = tt1;
        rnd[1] = r_wr[0];
        rnd[2] = rotl32(r_wr[1], 5'd9);
        rnd[3] = r_wr[2];
        rnd[4] = perm0(tt2);
        rnd[5] = r_wr[4];
        rnd[6] = rotl32(r_wr[5], 5'd19);
        rnd[7] = r_wr[6];
        w_new = perm1(r_win[0] ^ r_win[7] ^ rotl32(r_win[13], 5'd15))
              ^ rotl32(r_win[3], 5'd7) ^ r_win[10];
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_round    = r_round;
        n_idx      = r_idx;
        n_bitlen   = r_bitlen;
        n_pad_act  = r_pad_act;
        n_pend80   = r_pend80;
        n_len_hi   = r_len_hi;
        n_len_done = r_len_done;
        n_cv       = r_cv;
        n_wr       = r_wr;
        n_win      = r_win;
        push_en    = 1'b0;
        push_word  = 32'h0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    push_en = 1'b1;
                    if (!i_in_data.last_word) begin
                        n_bitlen  = r_bitlen + 64'd32;
                        push_word = i_in_data.message_word;
                    end else begin
                        n_bitlen  = r_bitlen + {58'd0, n_eff, 3'b000};
                        n_pad_act = 1'b1;
                        n_state   = S_PAD;
                        if (n_eff == FULL_BYTES) begin
                            push_word = i_in_data.message_word;
                            n_pend80  = 1'b1;
                        end else begin
                            push_word = pad_partial(i_in_data.message_word, n_eff[1:0]);
                        end
                    end
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                if (r_pend80) begin
                    push_word = PAD_MSB;
                    n_pend80  = 1'b0;
                end else if (r_cnt == CNT_LEN_HI) begin
                    push_word = r_bitlen[63:32];
                    n_len_hi  = 1'b1;
                end else if (r_cnt == CNT_LEN_LO && r_len_hi) begin
                    push_word  = r_bitlen[31:0];
                    n_len_done = 1'b1;
                end else begin
                    push_word = 32'h0;
                end
            end
            S_ROUND: begin
                n_wr    = rnd;
                n_round = r_round + 6'd1;
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[15] = w_new;
                if (r_round == ROUND_LAST) begin
                    n_round = 6'd0;
                    for (int k = 0; k < 8; k++) begin
                        n_cv[k] = r_cv[k] ^ rnd[k];
                    end
                    if (r_len_done) begin
                        n_state = S_OUT;
                        n_idx   = 3'd0;
                    end else if (r_pad_act) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == DIGEST_LAST) begin
                        n_cv       = SM3_IV;
                        n_bitlen   = 64'd0;
                        n_cnt      = 4'd0;
                        n_pad_act  = 1'b0;
                        n_pend80   = 1'b0;
                        n_len_hi   = 1'b0;
                        n_len_done = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Shift a word into the block buffer; start the rounds on a full block
        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[15] = push_word;
            n_cnt     = r_cnt + 4'd1;
            if (r_cnt == CNT_LEN_LO) begin
                n_state = S_ROUND;
                n_round = 6'd0;
                n_wr    = r_cv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= 4'd0;
            r_round    <= 6'd0;
            r_idx      <= 3'd0;
            r_bitlen   <= 64'd0;
            r_pad_act  <= 1'b0;
            r_pend80   <= 1'b0;
            r_len_hi   <= 1'b0;
            r_len_done <= 1'b0;
            r_cv       <= SM3_IV;
            r_wr       <= '{default: 32'h0};
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_round    <= n_round;
            r_idx      <= n_idx;
            r_bitlen   <= n_bitlen;
            r_pad_act  <= n_pad_act;
            r_pend80   <= n_pend80;
            r_len_hi   <= n_len_hi;
            r_len_done <= n_len_done;
            r_cv       <= n_cv;
            r_wr       <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    `SM3_ASSERT_NEVER(a_no_overlap, o_in_ready && o_out_valid, "input taken while digest pending")
    `SM3_ASSERT_NEXT(a_block_start,
        in_xfer && !i_in_data.last_word && r_cnt == CNT_LEN_LO,
        r_state == S_ROUND && r_round == 6'd0, "full block did not start rounds")
    `SM3_ASSERT_NEXT(a_digest_start,
        r_state == S_ROUND && r_round == ROUND_LAST && r_len_done,
        o_out_valid && o_out_data.digest_index == 3'd0, "digest did not start at word 0")
    `SM3_ASSERT_NEXT(a_digest_done,
        out_xfer && o_out_data.last_digest_word,
        o_in_ready && r_bitlen == 64'd0, "engine not rearmed after digest")

endmodule

`default_nettype wire
